/* rtl/qrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, status codes, pipeline control type and a magnitude helper for the
// quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int CoefW = 32;          // Q16.16 coefficient and root width
   localparam int StatW = 3;           // status code width
   localparam int ProdW = 2 * CoefW;   // magnitude product width
   localparam int DiscW = ProdW + 2;   // discriminant in Q34.32
   localparam int RootW = 35;          // square root result width
   localparam int RemW  = 72;          // square root remainder width
   localparam int NumW  = 50;          // divider numerator magnitude width
   localparam int DenW  = CoefW + 1;   // divider denominator magnitude width
   localparam int FracW = 16;          // fraction bits of Q16.16

   localparam logic [StatW-1:0] ST_OK        = 3'd0;
   localparam logic [StatW-1:0] ST_NEG_SQRT  = 3'd2;
   localparam logic [StatW-1:0] ST_INFINITE  = 3'd4;
   localparam logic [StatW-1:0] ST_NONE      = 3'd5;
   localparam logic [StatW-1:0] ST_NO_SECOND = 3'd6;

   // Control word that travels with each coefficient set.
   typedef struct packed {
      logic             valid;
      logic             lin;    // linear case, root one is -c/b
      logic             calc1;  // root one value comes from divider one
      logic             calc2;  // root two value comes from divider two
      logic [StatW-1:0] st1;
      logic [StatW-1:0] st2;
   } qrs_ctl_type;

   // Magnitude of a signed coefficient; the most negative value fits unsigned.
   function automatic logic [CoefW-1:0] qrs_mag(input logic [CoefW-1:0] v);
      return v[CoefW-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

/* rtl/quadratic_root_solver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Solves a*x^2 + b*x + c = 0 in signed Q16.16 with status propagation, the
// linear fallback for a zero a, and saturated roots, in a deep pipeline.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Contents
//   -------   ------------------   ------------------------------------------
//   request   start, busy          coef_a, coef_b, coef_c with their statuses
//   response  rsp_valid (strobe)   root_one, root_two with their statuses
//
// A transfer on the request side happens at each rising edge with start high;
// busy is always low, so a new coefficient set may enter in every cycle.
// The response strobe follows the accepting edge through the input register,
// the two product and discriminant stages, the 35 bit-per-stage square root
// stages, the divider input register, the 50 bit-per-stage divider stages
// and the output register.
// Reset clears all valid bits; the receiver cannot stall, so nothing waits.
//
module quadratic_root_solver (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [qrs_pkg::CoefW-1:0]   req_coef_a,
   input  logic [qrs_pkg::StatW-1:0]   req_coef_a_status,
   input  logic [qrs_pkg::CoefW-1:0]   req_coef_b,
   input  logic [qrs_pkg::StatW-1:0]   req_coef_b_status,
   input  logic [qrs_pkg::CoefW-1:0]   req_coef_c,
   input  logic [qrs_pkg::StatW-1:0]   req_coef_c_status,
   output logic                        rsp_valid,
   output logic [qrs_pkg::CoefW-1:0]   rsp_root_one,
   output logic [qrs_pkg::StatW-1:0]   rsp_root_one_status,
   output logic [qrs_pkg::CoefW-1:0]   rsp_root_two,
   output logic [qrs_pkg::StatW-1:0]   rsp_root_two_status
);
   import qrs_pkg::*;

   localparam int ExtW = RootW + 5;    // signed width for s - b and -b - s

   // The pipeline never holds off a transfer.
   assign busy = 1'b0;

   // ---------------------------------------------------------------------
   // Input stage. All outcome classes but a negative discriminant are set here:
   // an input error, the linear case and its special statuses, the quadratic case.
   // ---------------------------------------------------------------------
   qrs_ctl_type      ctl_in;
   qrs_ctl_type      in_ctl_ff;
   logic [CoefW-1:0] in_a_ff, in_b_ff, in_c_ff;

   always_comb begin
      ctl_in       = '0;
      ctl_in.valid = start & ~busy;
      if (req_coef_a_status != ST_OK) begin
         ctl_in.st1 = req_coef_a_status;
         ctl_in.st2 = req_coef_a_status;
      end else if (req_coef_b_status != ST_OK) begin
         ctl_in.st1 = req_coef_b_status;
         ctl_in.st2 = req_coef_b_status;
      end else if (req_coef_c_status != ST_OK) begin
         ctl_in.st1 = req_coef_c_status;
         ctl_in.st2 = req_coef_c_status;
      end else if (req_coef_a == '0) begin
         ctl_in.lin = 1'b1;
         ctl_in.st2 = ST_NO_SECOND;
         if (req_coef_b == '0) begin
            ctl_in.st1 = (req_coef_c == '0) ? ST_INFINITE : ST_NONE;
         end else begin
            ctl_in.calc1 = 1'b1;
         end
      end else begin
         ctl_in.calc1 = 1'b1;
         ctl_in.calc2 = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctl_ff <= '0;
      end else begin
         in_ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      in_a_ff <= req_coef_a;
      in_b_ff <= req_coef_b;
      in_c_ff <= req_coef_c;
   end

   // ---------------------------------------------------------------------
   // Product stage: b*b and |a*c| on magnitudes, plus the sign of a*c.
   // ---------------------------------------------------------------------
   qrs_ctl_type      pr_ctl_ff;
   logic [CoefW-1:0] pr_a_ff, pr_b_ff, pr_c_ff;
   logic [ProdW-1:0] pr_b2_ff, pr_p_ff;
   logic             pr_acneg_ff;
   logic [CoefW-1:0] in_a_mag, in_b_mag, in_c_mag;

   always_comb begin
      in_a_mag = qrs_mag(in_a_ff);
      in_b_mag = qrs_mag(in_b_ff);
      in_c_mag = qrs_mag(in_c_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_ctl_ff <= '0;
      end else begin
         pr_ctl_ff <= in_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      pr_a_ff     <= in_a_ff;
      pr_b_ff     <= in_b_ff;
      pr_c_ff     <= in_c_ff;
      pr_b2_ff    <= in_b_mag * in_b_mag;
      pr_p_ff     <= in_a_mag * in_c_mag;
      pr_acneg_ff <= in_a_ff[CoefW-1] ^ in_c_ff[CoefW-1];
   end

   // ---------------------------------------------------------------------
   // Discriminant stage: D = b*b - 4ac, exact in Q34.32. A negative D in
   // the quadratic case flags both roots.
   // ---------------------------------------------------------------------
   logic [DiscW-1:0] b2_ext, p4_ext, disc_in;
   logic             negd;
   qrs_ctl_type      dctl_in;

   always_comb begin
      b2_ext = {2'b00, pr_b2_ff};
      p4_ext = {pr_p_ff, 2'b00};
      negd   = 1'b0;
      if (pr_acneg_ff || (pr_p_ff == '0)) begin
         disc_in = b2_ext + p4_ext;
      end else begin
         negd    = p4_ext > b2_ext;
         disc_in = b2_ext - p4_ext;
      end
      dctl_in = pr_ctl_ff;
      if (negd && pr_ctl_ff.calc2) begin
         dctl_in.st1   = ST_NEG_SQRT;
         dctl_in.st2   = ST_NEG_SQRT;
         dctl_in.calc1 = 1'b0;
         dctl_in.calc2 = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Square root: one result bit per stage, most significant bit first.
   // The remainder holds D - r*r; setting bit k costs (r << (k+1)) + 4^k.
   // ---------------------------------------------------------------------
   qrs_ctl_type      sq_ctl_ff  [0:RootW];
   logic [CoefW-1:0] sq_a_ff    [0:RootW];
   logic [CoefW-1:0] sq_b_ff    [0:RootW];
   logic [CoefW-1:0] sq_c_ff    [0:RootW];
   logic [RemW-1:0]  sq_rem_ff  [0:RootW];
   logic [RootW-1:0] sq_root_ff [0:RootW];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ctl_ff[0] <= '0;
      end else begin
         sq_ctl_ff[0] <= dctl_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_a_ff[0]    <= pr_a_ff;
      sq_b_ff[0]    <= pr_b_ff;
      sq_c_ff[0]    <= pr_c_ff;
      sq_rem_ff[0]  <= RemW'(disc_in);
      sq_root_ff[0] <= '0;
   end

   for (genvar j = 0; j < RootW; j++) begin : g_sqrt
      localparam int K = RootW - 1 - j;
      logic [RemW-1:0]  trial;
      logic             take;
      logic [RemW-1:0]  rem_in;
      logic [RootW-1:0] root_in;

      always_comb begin
         trial   = (RemW'(sq_root_ff[j]) << (K + 1)) + (RemW'(1) << (2 * K));
         take    = trial <= sq_rem_ff[j];
         rem_in  = take ? (sq_rem_ff[j] - trial) : sq_rem_ff[j];
         root_in = take ? (sq_root_ff[j] | (RootW'(1) << K)) : sq_root_ff[j];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_ctl_ff[j+1] <= '0;
         end else begin
            sq_ctl_ff[j+1] <= sq_ctl_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         sq_a_ff[j+1]    <= sq_a_ff[j];
         sq_b_ff[j+1]    <= sq_b_ff[j];
         sq_c_ff[j+1]    <= sq_c_ff[j];
         sq_rem_ff[j+1]  <= rem_in;
         sq_root_ff[j+1] <= root_in;
      end
   end

   // ---------------------------------------------------------------------
   // Numerators and denominators in sign and magnitude form. Quadratic:
   // (s - b) / 2a and (-b - s) / 2a. Linear: -c / b on divider one.
   // ---------------------------------------------------------------------
   logic [ExtW-1:0]  s_ext, b_ext, d1, d2, m1, m2;
   logic [CoefW-1:0] a_mag, b_mag, c_mag;
   logic [NumW-1:0]  div1_num, div2_num;
   logic             div1_num_neg, div2_num_neg;
   logic [DenW-1:0]  div1_den, div2_den;
   logic             div1_den_neg, div2_den_neg;
   logic [CoefW-1:0] div1_quo, div2_quo;
   qrs_ctl_type      fin_ctl;

   always_comb begin
      fin_ctl = sq_ctl_ff[RootW];
      s_ext   = ExtW'(sq_root_ff[RootW]);
      b_ext   = {{(ExtW-CoefW){sq_b_ff[RootW][CoefW-1]}}, sq_b_ff[RootW]};
      d1      = s_ext - b_ext;
      d2      = (~b_ext + 1'b1) - s_ext;
      m1      = d1[ExtW-1] ? (~d1 + 1'b1) : d1;
      m2      = d2[ExtW-1] ? (~d2 + 1'b1) : d2;
      a_mag   = qrs_mag(sq_a_ff[RootW]);
      b_mag   = qrs_mag(sq_b_ff[RootW]);
      c_mag   = qrs_mag(sq_c_ff[RootW]);

      div2_num     = {m2[NumW-FracW-1:0], {FracW{1'b0}}};
      div2_num_neg = d2[ExtW-1];
      div2_den     = {a_mag, 1'b0};
      div2_den_neg = sq_a_ff[RootW][CoefW-1];

      if (fin_ctl.lin) begin
         div1_num     = NumW'({c_mag, {FracW{1'b0}}});
         div1_num_neg = ~sq_c_ff[RootW][CoefW-1];
         div1_den     = DenW'(b_mag);
         div1_den_neg = sq_b_ff[RootW][CoefW-1];
      end else begin
         div1_num     = {m1[NumW-FracW-1:0], {FracW{1'b0}}};
         div1_num_neg = d1[ExtW-1];
         div1_den     = div2_den;
         div1_den_neg = div2_den_neg;
      end
   end

   qrs_div #(.NW(NumW), .DW(DenW)) u_div_one (
      .clock   (clock),
      .num_mag (div1_num),
      .num_neg (div1_num_neg),
      .den_mag (div1_den),
      .den_neg (div1_den_neg),
      .quo     (div1_quo)
   );

   qrs_div #(.NW(NumW), .DW(DenW)) u_div_two (
      .clock   (clock),
      .num_mag (div2_num),
      .num_neg (div2_num_neg),
      .den_mag (div2_den),
      .den_neg (div2_den_neg),
      .quo     (div2_quo)
   );

   // The control word rides alongside the dividers, one register per stage.
   qrs_ctl_type dv_ctl_ff [0:NumW];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ctl_ff[0] <= '0;
      end else begin
         dv_ctl_ff[0] <= fin_ctl;
      end
   end

   for (genvar i = 0; i < NumW; i++) begin : g_ctl_delay
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ctl_ff[i+1] <= '0;
         end else begin
            dv_ctl_ff[i+1] <= dv_ctl_ff[i];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output register. A root whose status is nonzero reads as zero.
   // ---------------------------------------------------------------------
   logic             rsp_valid_ff;
   logic [CoefW-1:0] rsp_root_one_ff, rsp_root_two_ff;
   logic [StatW-1:0] rsp_st1_ff, rsp_st2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_ctl_ff[NumW].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_root_one_ff <= dv_ctl_ff[NumW].calc1 ? div1_quo : '0;
      rsp_root_two_ff <= dv_ctl_ff[NumW].calc2 ? div2_quo : '0;
      rsp_st1_ff      <= dv_ctl_ff[NumW].st1;
      rsp_st2_ff      <= dv_ctl_ff[NumW].st2;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_root_one        = rsp_root_one_ff;
   assign rsp_root_one_status = rsp_st1_ff;
   assign rsp_root_two        = rsp_root_two_ff;
   assign rsp_root_two_status = rsp_st2_ff;

endmodule

/* rtl/qrs_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider, one quotient bit per stage, with the signed
// quotient truncated toward zero and saturated to Q16.16 range.
// ----------------------------------------------------------------------------
module qrs_div #(
   parameter int NW = qrs_pkg::NumW,
   parameter int DW = qrs_pkg::DenW
) (
   input  logic                       clock,
   input  logic [NW-1:0]              num_mag,
   input  logic                       num_neg,
   input  logic [DW-1:0]              den_mag,
   input  logic                       den_neg,
   output logic [qrs_pkg::CoefW-1:0]  quo
);
   import qrs_pkg::*;

   logic [NW-1:0] num_ff [0:NW];
   logic [DW-1:0] den_ff [0:NW];
   logic [DW-1:0] rem_ff [0:NW];
   logic [NW-1:0] q_ff   [0:NW];
   logic          neg_ff [0:NW];

   always_ff @(posedge clock) begin
      num_ff[0] <= num_mag;
      den_ff[0] <= den_mag;
      rem_ff[0] <= '0;
      q_ff[0]   <= '0;
      neg_ff[0] <= num_neg ^ den_neg;
   end

   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic [DW:0]   rs;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [NW-1:0] q_in;

      always_comb begin
         rs     = {rem_ff[i], num_ff[i][NW-1-i]};
         diff   = rs - {1'b0, den_ff[i]};
         ge     = rs >= {1'b0, den_ff[i]};
         rem_in = ge ? diff[DW-1:0] : rs[DW-1:0];
         q_in   = {q_ff[i][NW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         num_ff[i+1] <= num_ff[i];
         den_ff[i+1] <= den_ff[i];
         rem_ff[i+1] <= rem_in;
         q_ff[i+1]   <= q_in;
         neg_ff[i+1] <= neg_ff[i];
      end
   end

   localparam logic [NW-1:0] MagMin = NW'(1) << (CoefW - 1);

   always_comb begin
      if (neg_ff[NW]) begin
         if (q_ff[NW] > MagMin) quo = {1'b1, {(CoefW-1){1'b0}}};
         else                   quo = CoefW'(~q_ff[NW] + 1'b1);
      end else begin
         if (q_ff[NW] >= MagMin) quo = {1'b0, {(CoefW-1){1'b1}}};
         else                    quo = q_ff[NW][CoefW-1:0];
      end
   end

endmodule
